// ----- hw/rtl/lcfr_pkg.sv -----
// Shared types and constants for the LED comet frame renderer.
// No dependencies.
`default_nettype none
package lcfr_pkg;
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_DIM   = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    localparam int POS_W = 16;
    localparam int LEN_W = 5;
    localparam int IDX_W = 6;
    localparam int COL_W = 8;

    typedef struct packed {
        req_t              req;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  length;
        logic [COL_W-1:0]  red;
        logic [COL_W-1:0]  green;
        logic [COL_W-1:0]  blue;
        logic [IDX_W-1:0]  pixel_index;
    } cmd_t;
endpackage
`default_nettype wire

// ----- hw/rtl/lcfr_front.sv -----
// Front end: accepts request transactions into a small command queue.
// Depends on lcfr_pkg.
`default_nettype none
module lcfr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire lcfr_pkg::cmd_t in_cmd,
    output logic                q_valid,
    input  wire logic           q_ready,
    output lcfr_pkg::cmd_t      q_cmd
);
    import lcfr_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/lcfr_back.sv -----
// Back end: frame store and sequencer for clear, dim, comet draw and read.
// Depends on lcfr_pkg.
`default_nettype none
module lcfr_back #(
    parameter int NUM_LEDS   = 64,
    parameter int MAX_LENGTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire lcfr_pkg::cmd_t  q_cmd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [23:0]          out_data
);
    import lcfr_pkg::*;

    localparam int AW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int RING  = 3 * NUM_LEDS;
    localparam int SW    = $clog2(RING) + 1;
    localparam int LW    = $clog2(MAX_LENGTH + 1);
    localparam int IW    = $clog2(3 * MAX_LENGTH + 1);
    localparam int DW    = $clog2(9 * MAX_LENGTH + 1);
    localparam int NW    = COL_W + IW;
    localparam int CW    = AW + 1;
    // sub-position / 3 by reciprocal multiplication
    localparam int RK    = SW + 1;
    localparam int MUL3  = (2 ** RK) / 3 + 1;
    // bias that makes any 16-bit signed position non-negative, multiple of 3N
    localparam int PM_BIAS = 32768 + RING - (32768 % RING);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SWEEP = 7'b0000010,
        S_RDW   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_RMW   = 7'b0010000,
        S_READ  = 7'b0100000,
        S_OUT   = 7'b1000000
    } st_t;

    st_t             st_reg;
    logic [23:0]     mem [NUM_LEDS];
    logic [23:0]     rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            dim_reg;
    logic            lead_reg;
    logic [IW-1:0]   i_reg, span_reg;
    logic [SW-1:0]   sub_reg;
    logic [DW-1:0]   div_reg;
    logic [COL_W-1:0] r_reg, g_reg, b_reg;
    logic [NW-1:0]   nr_reg, ng_reg, nb_reg;
    logic [COL_W-1:0] qr_reg, qg_reg, qb_reg;
    logic [AW-1:0]   led_reg;
    logic [23:0]     out_reg;
    logic            ov_reg;

    // start sub-position mod 3N, sequential subtract
    logic [17:0]     pm_reg;
    logic            pm_busy_reg;

    logic [LW-1:0]   len_sat;
    logic [SW+RK-1:0] sub_prod;
    logic [AW-1:0]   led_of_sub;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [23:0]     mem_wd;
    logic [AW-1:0]   mem_ra;

    assign len_sat = (32'(q_cmd.length) > MAX_LENGTH) ? LW'(MAX_LENGTH)
                                                      : LW'(q_cmd.length);
    assign sub_prod   = (SW+RK)'(sub_reg) * (SW+RK)'(MUL3);
    assign led_of_sub = AW'(sub_prod >> RK);
    assign q_ready  = (st_reg == S_IDLE) && !pm_busy_reg && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // long division: NW-bit numerators over DW-bit divisor, 3 lanes, one bit a cycle
    logic [DW:0]     rem_r, rem_g, rem_b;
    logic [DW:0]     tr, tg, tb;
    logic [4:0]      bit_reg;
    assign tr = {rem_r[DW-1:0], nr_reg[NW-1]};
    assign tg = {rem_g[DW-1:0], ng_reg[NW-1]};
    assign tb = {rem_b[DW-1:0], nb_reg[NW-1]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[mem_ra];
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = led_reg;
        mem_wd = rd_reg;
        mem_ra = led_reg;
        case (st_reg)
            S_SWEEP:
            begin
                mem_ra = cnt_reg[AW-1:0];
                if (!dim_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = cnt_reg[AW-1:0];
                    mem_wd = '0;
                end
                else if (cnt_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = AW'(cnt_reg - 1'b1);
                    mem_wd = {1'b0, rd_reg[23:17], 1'b0, rd_reg[15:9], 1'b0, rd_reg[7:1]};
                end
            end
            S_RMW:
            begin
                mem_we = 1'b1;
                mem_wd = {rd_reg[23:16] + qr_reg, rd_reg[15:8] + qg_reg,
                          rd_reg[7:0] + qb_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // clearing pass over the whole frame
            st_reg      <= S_SWEEP;
            dim_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            pm_busy_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (pm_busy_reg)
                    begin
                        if (pm_reg >= 18'(RING))
                        begin
                            pm_reg <= pm_reg - 18'(RING);
                        end
                        else
                        begin
                            pm_busy_reg <= 1'b0;
                            // leading half starts at pos + 3L - 1
                            sub_reg  <= SW'(pm_reg);
                            i_reg    <= IW'(1);
                            lead_reg <= 1'b1;
                            st_reg   <= S_RDW;
                        end
                    end
                    else if (q_valid && q_ready)
                    begin
                        case (q_cmd.req)
                            REQ_CLEAR, REQ_DIM:
                            begin
                                dim_reg <= (q_cmd.req == REQ_DIM);
                                cnt_reg <= '0;
                                st_reg  <= S_SWEEP;
                            end
                            REQ_DRAW:
                            begin
                                if (q_cmd.length != '0)
                                begin
                                    span_reg <= IW'(3 * 32'(len_sat));
                                    div_reg  <= DW'(9 * 32'(len_sat));
                                    r_reg <= q_cmd.red;
                                    g_reg <= q_cmd.green;
                                    b_reg <= q_cmd.blue;
                                    pm_reg <= 18'(int'($signed(q_cmd.position)) + PM_BIAS +
                                              3 * int'(len_sat) - 1);
                                    pm_busy_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                if (32'(q_cmd.pixel_index) < NUM_LEDS)
                                begin
                                    led_reg <= AW'(q_cmd.pixel_index);
                                    st_reg  <= S_READ;
                                end
                                else
                                begin
                                    out_reg <= '0;
                                    ov_reg  <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_SWEEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if ((!dim_reg && cnt_reg == CW'(NUM_LEDS - 1)) ||
                        (dim_reg && cnt_reg == CW'(NUM_LEDS)))
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_RDW:
                begin
                    led_reg <= led_of_sub;
                    nr_reg  <= NW'(r_reg) * NW'(i_reg);
                    ng_reg  <= NW'(g_reg) * NW'(i_reg);
                    nb_reg  <= NW'(b_reg) * NW'(i_reg);
                    rem_r <= '0;
                    rem_g <= '0;
                    rem_b <= '0;
                    bit_reg <= 5'(NW);
                    st_reg  <= S_DIV;
                end
                S_DIV:
                begin
                    nr_reg <= {nr_reg[NW-2:0], (tr >= (DW+1)'(div_reg))};
                    ng_reg <= {ng_reg[NW-2:0], (tg >= (DW+1)'(div_reg))};
                    nb_reg <= {nb_reg[NW-2:0], (tb >= (DW+1)'(div_reg))};
                    rem_r <= (tr >= (DW+1)'(div_reg)) ? tr - (DW+1)'(div_reg) : tr;
                    rem_g <= (tg >= (DW+1)'(div_reg)) ? tg - (DW+1)'(div_reg) : tg;
                    rem_b <= (tb >= (DW+1)'(div_reg)) ? tb - (DW+1)'(div_reg) : tb;
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 5'd1)
                    begin
                        qr_reg <= COL_W'({nr_reg[NW-2:0], (tr >= (DW+1)'(div_reg))});
                        qg_reg <= COL_W'({ng_reg[NW-2:0], (tg >= (DW+1)'(div_reg))});
                        qb_reg <= COL_W'({nb_reg[NW-2:0], (tb >= (DW+1)'(div_reg))});
                        st_reg <= S_RMW;
                    end
                end
                S_RMW:
                begin
                    st_reg  <= S_RDW;
                    sub_reg <= (sub_reg == '0) ? SW'(RING - 1) : sub_reg - 1'b1;
                    if (lead_reg)
                    begin
                        if (i_reg == span_reg - 1'b1)
                        begin
                            // trailing half starts at pos, one below the last leading step
                            lead_reg <= 1'b0;
                            i_reg    <= span_reg;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (i_reg == IW'(1))
                        begin
                            st_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg <= i_reg - 1'b1;
                        end
                    end
                end
                S_READ:
                begin
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_reg <= rd_reg;
                    ov_reg  <= 1'b1;
                    st_reg  <= S_IDLE;
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/led_comet_frame_renderer_core.sv -----
// Top level of the LED comet frame renderer: command queue plus frame engine.
// Depends on lcfr_pkg, lcfr_front, lcfr_back.
//
// Slave stream s_axis_*: one request per transaction (clear, draw, dim, read).
// Master stream m_axis_*: one pixel per read request, none for the others.
// A two-entry queue lets requests be taken while the engine is busy.
// Clear writes zero to every pixel; dim reads each pixel and writes it back
// halved (read then write back). A draw first reduces its start position
// modulo 3*NUM_LEDS by repeated subtraction, then runs 6L-1 steps, each a
// bit-serial divide by 9L. A read passes the engine through the S_READ and
// S_OUT states; its result is registered in out_reg.
// After reset the engine clears the frame before it takes any request;
// the queue accepts meanwhile.
// While the result waits for m_axis_tready the engine takes no new request;
// the queue keeps accepting until it is full.
`default_nettype none
module led_comet_frame_renderer_core #(
    parameter int NUM_LEDS   = 64,
    parameter int MAX_LENGTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // position, length, red_in, green_in, blue_in, pixel_index (51 bits, 56 wide)
    input  wire logic [55:0] s_axis_tdata,
    // req_type
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // red_out, green_out, blue_out
    output logic [23:0]      m_axis_tdata
);
    import lcfr_pkg::*;

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    logic [23:0] od;

    assign in_cmd.req         = req_t'(s_axis_tuser);
    assign in_cmd.position    = s_axis_tdata[15:0];
    assign in_cmd.length      = s_axis_tdata[20:16];
    assign in_cmd.red         = s_axis_tdata[28:21];
    assign in_cmd.green       = s_axis_tdata[36:29];
    assign in_cmd.blue        = s_axis_tdata[44:37];
    assign in_cmd.pixel_index = s_axis_tdata[50:45];

    lcfr_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    lcfr_back #(.NUM_LEDS(NUM_LEDS), .MAX_LENGTH(MAX_LENGTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
    );

    assign m_axis_tdata = {od[7:0], od[15:8], od[23:16]};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_q: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |-> !m_axis_tvalid)
        else $error("engine took request with result pending");
endmodule
`default_nettype wire

// ----- sim/tb_led_comet_frame_renderer_core.sv -----
// Testbench for led_comet_frame_renderer_core: drives requests on the input stream,
// predicts every pixel read in a scoreboard and checks results from the output stream.
// Depends on lcfr_pkg and the renderer RTL.
`timescale 1ns / 1ps
module tb_led_comet_frame_renderer_core;
    import lcfr_pkg::*;

    localparam int LEDS    = 64;
    localparam int MAX_LEN = 16;
    localparam int SUBS    = 3 * LEDS;
    localparam int N_RAND  = 1730;
    localparam int N_QUIET = 250;

    class frame_scoreboard;
        logic [7:0]  red_px[LEDS];
        logic [7:0]  grn_px[LEDS];
        logic [7:0]  blu_px[LEDS];
        logic [23:0] pixel_q[$];

        function new();
            blank();
        endfunction

        function void blank();
            for (int a = 0; a < LEDS; a++)
            begin
                red_px[a] = 0;
                grn_px[a] = 0;
                blu_px[a] = 0;
            end
        endfunction

        function int wrap_sub(int x);
            int r;
            r = x % SUBS;
            if (r < 0)
                r += SUBS;
            return r;
        endfunction

        function void add_sub(int sub, int step, int len, int r, int g, int b);
            int led;
            led = wrap_sub(sub) / 3;
            red_px[led] = 8'(red_px[led] + (r * step) / (9 * len));
            grn_px[led] = 8'(grn_px[led] + (g * step) / (9 * len));
            blu_px[led] = 8'(blu_px[led] + (b * step) / (9 * len));
        endfunction

        function void note(req_t req, logic signed [15:0] pos, logic [4:0] len_in,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [5:0] idx);
            int len;
            int p;
            len = len_in;
            case (req)
                REQ_CLEAR: blank();
                REQ_DRAW:
                begin
                    if (len != 0)
                    begin
                        if (len > MAX_LEN)
                            len = MAX_LEN;
                        p = wrap_sub(int'(pos));
                        for (int i = 1; i < 3 * len; i++)
                            add_sub(p + 3 * len - i, i, len, r, g, b);
                        for (int i = 3 * len; i >= 1; i--)
                            add_sub(p + i - 3 * len, i, len, r, g, b);
                    end
                end
                REQ_DIM:
                    for (int a = 0; a < LEDS; a++)
                    begin
                        red_px[a] = red_px[a] >> 1;
                        grn_px[a] = grn_px[a] >> 1;
                        blu_px[a] = blu_px[a] >> 1;
                    end
                default: pixel_q.push_back({blu_px[idx], grn_px[idx], red_px[idx]});
            endcase
        endfunction

        function bit check(output logic [23:0] exp_px);
            if (pixel_q.size() == 0)
                return 0;
            exp_px = pixel_q.pop_front();
            return 1;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;

    frame_scoreboard sb = new();
    int  errors = 0;
    bit  quiet = 0;
    int  rx_stall = 0;

    led_comet_frame_renderer_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task send(req_t req, logic [15:0] pos, logic [4:0] len, logic [7:0] r,
              logic [7:0] g, logic [7:0] b, logic [5:0] idx);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tdata  <= {5'b0, idx, b, g, r, len, pos};
        s_axis_tuser  <= req;
        s_axis_tvalid <= 1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note(req, pos, len, r, g, b, idx);
    endtask

    task send_random();
        int k;
        logic [4:0] len;
        req_t req;
        k = $urandom_range(0, 99);
        if (k < 4)
            req = REQ_CLEAR;
        else if (k < 40)
            req = REQ_DRAW;
        else if (k < 50)
            req = REQ_DIM;
        else
            req = REQ_READ;
        k = $urandom_range(0, 99);
        if (k < 88)
            len = 5'($urandom_range(1, 4));
        else if (k < 95)
            len = 5'($urandom_range(0, 31));
        else
            len = 5'(MAX_LEN);
        send(req, 16'($urandom), len, 8'($urandom), 8'($urandom), 8'($urandom),
             6'($urandom));
    endtask

    always @(posedge clk)
    begin
        logic [23:0] exp_px;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (!sb.check(exp_px))
                report("unexpected transaction", m_axis_tdata, 0);
            else
            begin
                if (m_axis_tdata[7:0] !== exp_px[7:0])
                    report("red_out", m_axis_tdata[7:0], exp_px[7:0]);
                if (m_axis_tdata[15:8] !== exp_px[15:8])
                    report("green_out", m_axis_tdata[15:8], exp_px[15:8]);
                if (m_axis_tdata[23:16] !== exp_px[23:16])
                    report("blue_out", m_axis_tdata[23:16], exp_px[23:16]);
            end
        end
        if (quiet || !rst_n)
            m_axis_tready <= rst_n;
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rx_stall = $urandom_range(0, 8);
            m_axis_tready <= 0;
        end
        else
            m_axis_tready <= 1;
    end

    initial
    begin
        #200_000_000;
        $display("tb_led_comet_frame_renderer_core NOT OK");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        send(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 0);
        send(REQ_DRAW, 0, 1, 8'hff, 8'hff, 8'hff, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 63);
        send(REQ_READ, 0, 0, 0, 0, 0, 1);
        send(REQ_DRAW, 16'h8000, 5'(MAX_LEN), 8'hff, 8'h00, 8'h80, 6'h2a);
        send(REQ_READ, 0, 0, 0, 0, 0, 63);
        send(REQ_READ, 0, 0, 0, 0, 0, 21);
        send(REQ_DRAW, 16'h7fff, 0, 8'hff, 8'hff, 8'hff, 0);
        send(REQ_DRAW, 16'hffff, 5'd31, 8'h55, 8'haa, 8'hff, 0);
        send(REQ_DRAW, 100, 5'd17, 8'h01, 8'hfe, 8'h7f, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 33);
        send(REQ_DIM, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 32);
        send(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 32);
        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == N_RAND / 2)
            begin
                s_axis_tvalid <= 0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (n == N_RAND - N_QUIET)
                quiet = 1;
            send_random();
        end
        s_axis_tvalid <= 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (errors == 0 && sb.pending() == 0)
            $display("tb_led_comet_frame_renderer_core OK");
        else
            $display("tb_led_comet_frame_renderer_core NOT OK");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/lcfr_pkg.sv
hw/rtl/lcfr_front.sv
hw/rtl/lcfr_back.sv
hw/rtl/led_comet_frame_renderer_core.sv
sim/tb_led_comet_frame_renderer_core.sv
